### src/nps_pkg.sv
package nps_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int ADDR_ENTRIES        = 256;  // reach of the 8-bit index fields
	localparam int IDX_W               = 8;
	localparam int COLOR_W             = 24;
	localparam int CH_W                = 8;
	localparam int SQ_W                = 16;
	localparam int DIST_W              = 18;
	localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [DIST_W-1:0]  dist_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

endpackage

### src/nearest_palette_color_search_core.sv
// Write word: accepted when idle, no result.
// Query word: scans min(PALETTE_ENTRIES, 256) entries, one read per cycle from the
// palette RAM read port; out_valid rises once the last entry has passed the pipeline stages
// and the compare. Input stalls until the result is loaded, and a scan end
// waits while the previous result is still unaccepted.
// Reset (arst_n, async low) clears control and the per-entry valid bits, so every
// palette entry reads as black until written; no clearing pass is needed.
module nearest_palette_color_search_core #(
	parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [nps_pkg::IDX_W-1:0]  entry_index,
	input  nps_pkg::color_t            color_rgb,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [nps_pkg::IDX_W-1:0]  nearest_index,
	output nps_pkg::dist_t             nearest_distance
);

	localparam int DEPTH = (PALETTE_ENTRIES < nps_pkg::ADDR_ENTRIES) ?
		PALETTE_ENTRIES : nps_pkg::ADDR_ENTRIES;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT} state_t;

	state_t state_q;

	nps_pkg::color_t mem [DEPTH];
	logic [DEPTH-1:0] ent_valid_q;

	logic            in_acc, wr_en;
	logic            out_load;
	logic [AW-1:0]   rd_addr_q;
	nps_pkg::color_t query_q;

	// pipeline: s1 RAM data, s2 squares, s3 distance, then compare into best
	logic                       v_s1, v_s2, v_s3;
	logic                       last_s1, last_s2, last_s3;
	logic [AW-1:0]              idx_s1, idx_s2, idx_s3;
	nps_pkg::color_t            pix_s1;
	logic                       pv_s1;
	logic [nps_pkg::SQ_W-1:0]   sqr_s2, sqg_s2, sqb_s2;
	nps_pkg::dist_t             dist_s3;
	nps_pkg::color_t            pix;

	logic [AW-1:0]   best_idx_q;
	nps_pkg::dist_t  best_dist_q;
	logic            fin_q;
	logic            out_valid_q;
	logic [nps_pkg::IDX_W-1:0] out_idx_q;
	nps_pkg::dist_t  out_dist_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	// writes past the palette are dropped; only taken while idle, so no RAM hazard
	assign wr_en    = in_acc && (operation == nps_pkg::OP_WRITE) &&
		(32'(entry_index) < DEPTH);
	// result register loads once the scan is done and the old word is gone
	assign out_load = (state_q == ST_WAIT) && fin_q && (!out_valid_q || out_ready);

	assign out_valid        = out_valid_q;
	assign nearest_index    = out_idx_q;
	assign nearest_distance = out_dist_q;

	// palette RAM, at most one write and one read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[entry_index[AW-1:0]] <= color_rgb;
		end
		pix_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
		end else if (wr_en) begin
			ent_valid_q[entry_index[AW-1:0]] <= 1'b1;
		end
	end

	// never-written entries read as black
	assign pix = pv_s1 ? pix_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_SCAN);
			last_s1 <= (state_q == ST_SCAN) && (rd_addr_q == LAST_ADDR);
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			v_s3    <= v_s2;
			last_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_addr_q;
		pv_s1   <= ent_valid_q[rd_addr_q];
		idx_s2  <= idx_s1;
		sqr_s2  <= nps_pkg::sq_diff(pix[23:16], query_q[23:16]);
		sqg_s2  <= nps_pkg::sq_diff(pix[15:8], query_q[15:8]);
		sqb_s2  <= nps_pkg::sq_diff(pix[7:0], query_q[7:0]);
		idx_s3  <= idx_s2;
		dist_s3 <= nps_pkg::DIST_W'(sqr_s2) + nps_pkg::DIST_W'(sqg_s2) +
			nps_pkg::DIST_W'(sqb_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_addr_q   <= '0;
			query_q     <= '0;
			best_idx_q  <= '0;
			best_dist_q <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_dist_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// strict compare: lowest index wins a tie; entry 0 always seeds
			if (v_s3 && ((idx_s3 == '0) || (dist_s3 < best_dist_q))) begin
				best_idx_q  <= idx_s3;
				best_dist_q <= dist_s3;
			end
			if (v_s3 && last_s3) begin
				fin_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					rd_addr_q <= '0;
					if (in_acc && (operation == nps_pkg::OP_QUERY)) begin
						query_q <= color_rgb;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_addr_q <= rd_addr_q + 1'b1;
					if (rd_addr_q == LAST_ADDR) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_load) begin
						out_idx_q   <= nps_pkg::IDX_W'(best_idx_q);
						out_dist_q  <= best_dist_q;
						fin_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(v_s1 || v_s2 || v_s3 || fin_q))
		else $error("scan pipeline busy while idle");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (dist_s3 <= nps_pkg::MAX_DIST))
		else $error("distance out of range");

	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1 && last_s1, v_s2 && last_s2, v_s3 && last_s3, fin_q}))
		else $error("more than one scan end in flight");

	a_fin_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (state_q == ST_WAIT))
		else $error("scan finished outside wait state");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_WAIT) && (state_q == ST_IDLE))
		else $error("result loaded outside scan end");

endmodule
